// ===== rtl/core/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types, constants and codes shared by the route table modules.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int NODE_ID_BITS = 8;
    localparam int COST_BITS    = 16;
    localparam int SEQ_W        = 32;
    localparam int CFG_W        = 32;

    localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

    localparam logic [1:0] FUNC_ADV   = 2'd0;
    localparam logic [1:0] FUNC_BREAK = 2'd1;
    localparam logic [1:0] FUNC_LOOK  = 2'd2;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_REFRESH = 3'd1;
    localparam logic [2:0] ACT_REPLACE = 3'd2;
    localparam logic [2:0] ACT_INSERT  = 3'd3;
    localparam logic [2:0] ACT_FULL    = 3'd4;
    localparam logic [2:0] ACT_OWN_ODD = 3'd5;
    localparam logic [2:0] ACT_BROKEN  = 3'd6;

    localparam logic CFG_SELF_ID  = 1'b0;
    localparam logic CFG_SELF_SEQ = 1'b1;

    typedef struct packed {
        logic [1:0]              func;
        logic [NODE_ID_BITS-1:0] dest_id;
        logic [COST_BITS-1:0]    adv_cost;
        logic [SEQ_W-1:0]        adv_seq;
        logic [COST_BITS-1:0]    link_cost;
        logic                    first_row;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic [NODE_ID_BITS-1:0] next_hop;
        logic [COST_BITS-1:0]    route_cost;
        logic [2:0]              action;
        logic                    broken_link;
    } t_rsp;

    typedef struct packed {
        logic [NODE_ID_BITS-1:0] dest;
        logic [NODE_ID_BITS-1:0] next;
        logic [COST_BITS-1:0]    cost;
        logic [SEQ_W-1:0]        seq;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        t_entry                  wdata;
        logic                    count_inc;
        logic                    nb_we;
        logic [NODE_ID_BITS-1:0] nb;
        logic                    newer;
    } t_upd;

endpackage

// ===== rtl/core/dvrt_ram.sv =====
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/dvrt_update.sv =====
// ----------------------------------------------------------------------------
// dvrt_update
// Decides the table write and the result of one request after the scan.
// ----------------------------------------------------------------------------
module dvrt_update import dvrt_pkg::*; (
    input  t_req                    i_req,
    input  logic [NODE_ID_BITS-1:0] i_self_id,
    input  logic [SEQ_W-1:0]        i_self_seq,
    input  logic                    i_hit,
    input  logic [ADDR_W-1:0]       i_hit_idx,
    input  t_entry                  i_hit_data,
    input  logic                    i_brk,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [NODE_ID_BITS-1:0] i_cur_nb,
    input  logic                    i_newer,
    output t_upd                    o_upd,
    output t_rsp                    o_rsp
);

    logic                 is_self;
    logic                 hit_ok;
    logic [COST_BITS:0]   raw_sum;
    logic [COST_BITS-1:0] sum;
    logic                 room;
    t_entry               d;

    assign is_self = (i_req.dest_id == i_self_id);
    assign hit_ok  = i_hit && !is_self;
    assign raw_sum = {1'b0, i_req.adv_cost} + {1'b0, i_req.link_cost};
    assign sum     = (i_req.adv_cost == COST_INF || raw_sum >= {1'b0, COST_INF})
                     ? COST_INF : raw_sum[COST_BITS-1:0];
    assign room    = (i_count < CNT_W'(TABLE_DEPTH));

    always_comb begin
        o_upd             = '0;
        o_upd.waddr       = i_hit_idx;
        o_upd.nb          = i_req.first_row ? i_req.dest_id : i_cur_nb;
        o_upd.newer       = i_newer;
        o_rsp             = '0;
        o_rsp.route_cost  = COST_INF;
        o_rsp.action      = ACT_NONE;
        d                 = i_hit_data;
        o_upd.wdata       = d;
        case (i_req.func)
            FUNC_ADV: begin
                o_rsp.found = is_self || hit_ok;
                o_upd.nb_we = i_req.first_row;
                if (i_req.first_row) begin
                    if (is_self) begin
                        o_upd.newer = i_req.adv_seq > i_self_seq;
                    end else if (hit_ok) begin
                        o_upd.newer = i_req.adv_seq > i_hit_data.seq;
                    end else begin
                        o_upd.newer = 1'b1;
                    end
                end
                if (is_self) begin
                    if (i_req.adv_seq[0]) begin
                        o_rsp.action      = ACT_OWN_ODD;
                        o_rsp.broken_link = 1'b1;
                    end
                    o_rsp.next_hop   = i_self_id;
                    o_rsp.route_cost = '0;
                end else if (hit_ok) begin
                    if (d.next == o_upd.nb && o_upd.newer) begin
                        d.cost       = sum;
                        o_rsp.action = ACT_REFRESH;
                    end else if (i_req.adv_seq > d.seq) begin
                        if ((d.cost == COST_INF) != (i_req.adv_cost == COST_INF)
                            || i_req.adv_cost == COST_INF) begin
                            o_rsp.broken_link = 1'b1;
                        end
                        d.next       = o_upd.nb;
                        d.cost       = sum;
                        d.seq        = i_req.adv_seq;
                        o_rsp.action = ACT_REPLACE;
                    end else if (i_req.adv_seq == d.seq && d.cost >= sum) begin
                        d.next       = o_upd.nb;
                        d.cost       = sum;
                        o_rsp.action = ACT_REPLACE;
                    end
                    o_upd.we         = (o_rsp.action != ACT_NONE);
                    o_upd.wdata      = d;
                    o_rsp.next_hop   = d.next;
                    o_rsp.route_cost = d.cost;
                end else if (room) begin
                    // A first row from an unknown neighbour lands here too:
                    // its own route is then next hop itself at the summed cost.
                    d.dest           = i_req.dest_id;
                    d.next           = o_upd.nb;
                    d.cost           = sum;
                    d.seq            = i_req.adv_seq;
                    o_upd.we         = 1'b1;
                    o_upd.waddr      = i_count[ADDR_W-1:0];
                    o_upd.wdata      = d;
                    o_upd.count_inc  = 1'b1;
                    o_rsp.action     = ACT_INSERT;
                    o_rsp.next_hop   = d.next;
                    o_rsp.route_cost = d.cost;
                end else begin
                    o_rsp.action = ACT_FULL;
                end
            end
            FUNC_BREAK, FUNC_LOOK: begin
                o_rsp.found = is_self || hit_ok;
                if (i_req.func == FUNC_BREAK && i_brk) begin
                    o_rsp.action      = ACT_BROKEN;
                    o_rsp.broken_link = 1'b1;
                end
                if (is_self) begin
                    o_rsp.next_hop   = i_self_id;
                    o_rsp.route_cost = '0;
                end else if (hit_ok) begin
                    o_rsp.next_hop   = i_hit_data.next;
                    o_rsp.route_cost = i_hit_data.cost;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector route table with a fixed self entry, held in one RAM.
// ----------------------------------------------------------------------------
// Operation: after the start edge the scan reads entries 1 .. entry_count-1
// from the RAM, waits for the last registered read, closes the scan and
// evaluates in ST_EVAL, from which the o_valid strobe is registered. busy
// drops in the strobe cycle; a new request is taken only after that result.
// Reset is synchronous and active low; it clears the control state and the
// neighbour state and sets the entry count back to one. Results cannot be stalled.
// ----------------------------------------------------------------------------
module distance_vector_route_table import dvrt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_valid,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0]              r_state;
    t_req                    r_req;
    logic [NODE_ID_BITS-1:0] r_self_id;
    logic [SEQ_W-1:0]        r_self_seq;
    logic [CNT_W-1:0]        r_count;
    logic [NODE_ID_BITS-1:0] r_cur_nb;
    logic                    r_newer;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_pend;
    logic [ADDR_W-1:0]       r_pidx;
    logic                    r_hit;
    logic [ADDR_W-1:0]       r_hidx;
    t_entry                  r_hdata;
    logic                    r_brk;
    logic                    r_valid;
    t_rsp                    r_rsp;

    logic   issue;
    logic   brk_match;
    t_entry rdata;
    t_entry mdata;
    t_upd   upd;
    t_rsp   rsp;
    logic   we;
    logic [ADDR_W-1:0] waddr;
    t_entry wdata;
    logic [ENTRY_W-1:0] rdata_raw;

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Entries 1 .. count-1 are read in turn; the self entry lives in registers.
    assign issue = (r_state == ST_SCAN) && (r_addr < r_count);
    assign rdata = rdata_raw;

    // During a link break every route through the broken hop is rewritten
    // when its registered read data comes back, while the next entry is being read.
    assign brk_match = r_pend && (r_req.func == FUNC_BREAK) && (rdata.next == r_req.dest_id);

    always_comb begin
        mdata = rdata;
        if (brk_match) begin
            mdata.cost = COST_INF;
            mdata.seq  = rdata.seq + SEQ_W'(1);
        end
    end

    always_comb begin
        if (r_state == ST_EVAL) begin
            we    = upd.we;
            waddr = upd.waddr;
            wdata = upd.wdata;
        end else begin
            we    = brk_match;
            waddr = r_pidx;
            wdata = mdata;
        end
    end

    dvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (rdata_raw)
    );

    dvrt_update u_update (
        .i_req      (r_req),
        .i_self_id  (r_self_id),
        .i_self_seq (r_self_seq),
        .i_hit      (r_hit),
        .i_hit_idx  (r_hidx),
        .i_hit_data (r_hdata),
        .i_brk      (r_brk),
        .i_count    (r_count),
        .i_cur_nb   (r_cur_nb),
        .i_newer    (r_newer),
        .o_upd      (upd),
        .o_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_self_id  <= '0;
            r_self_seq <= '0;
            r_count    <= CNT_W'(1);
            r_cur_nb   <= '0;
            r_newer    <= 1'b0;
            r_pend     <= 1'b0;
            r_valid    <= 1'b0;
            r_hit      <= 1'b0;
            r_brk      <= 1'b0;
            r_addr     <= CNT_W'(1);
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SELF_ID:  r_self_id  <= i_cfg_data[NODE_ID_BITS-1:0];
                    CFG_SELF_SEQ: r_self_seq <= i_cfg_data[SEQ_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_pend <= issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_SCAN;
                        r_addr  <= CNT_W'(1);
                        r_hit   <= 1'b0;
                        r_brk   <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_addr <= r_addr + CNT_W'(1);
                    end
                    if (brk_match) begin
                        r_brk <= 1'b1;
                    end
                    if (r_pend && !r_hit && rdata.dest == r_req.dest_id) begin
                        r_hit <= 1'b1;
                    end
                    if (!issue && !r_pend) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_state <= ST_IDLE;
                    r_valid <= 1'b1;
                    if (upd.count_inc) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (upd.nb_we) begin
                        r_cur_nb <= upd.nb;
                        r_newer  <= upd.newer;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_req <= i_req;
        end
        r_pidx <= r_addr[ADDR_W-1:0];
        if (r_state == ST_SCAN && r_pend && !r_hit && rdata.dest == r_req.dest_id) begin
            r_hidx  <= r_pidx;
            r_hdata <= mdata;
        end
        if (r_state == ST_EVAL) begin
            r_rsp <= rsp;
        end
    end

endmodule

// ===== tb/sv/tb_distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// tb_distance_vector_route_table
// Self-checking testbench for the distance-vector route table. Requests are
// driven through the start/busy handshake and predicted by a behavioral copy
// of the table. Every o_valid strobe is compared field by field against the
// oldest predicted response.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             o_valid;
    t_rsp             o_rsp;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    distance_vector_route_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // The model of the table. Entry zero is implied by the self registers.
    logic [NODE_ID_BITS-1:0] mdl_dest [TABLE_DEPTH];
    logic [NODE_ID_BITS-1:0] mdl_next [TABLE_DEPTH];
    logic [COST_BITS-1:0]    mdl_cost [TABLE_DEPTH];
    logic [SEQ_W-1:0]        mdl_seq  [TABLE_DEPTH];
    int                      mdl_count;
    logic [NODE_ID_BITS-1:0] mdl_nbr;
    logic                    mdl_newer;
    logic [NODE_ID_BITS-1:0] mdl_self_id;
    logic [SEQ_W-1:0]        mdl_self_seq;

    t_rsp pending_rsp [$];
    int   error_count;
    int   idle_cycles;
    bit   no_idle;

    // Clock with an 8 unit period.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Index of the learned entry for a destination, zero when there is none.
    function automatic int find_route(logic [NODE_ID_BITS-1:0] dest);
        for (int i = 1; i < mdl_count; i++) begin
            if (mdl_dest[i] == dest) return i;
        end
        return 0;
    endfunction

    // Appends a learned route and returns its index, zero when the table is full.
    function automatic int add_route(logic [NODE_ID_BITS-1:0] dest,
                                     logic [NODE_ID_BITS-1:0] nxt,
                                     logic [COST_BITS-1:0] cost,
                                     logic [SEQ_W-1:0] seq);
        int idx;
        idx = mdl_count;
        if (idx >= TABLE_DEPTH) return 0;
        mdl_dest[idx] = dest;
        mdl_next[idx] = nxt;
        mdl_cost[idx] = cost;
        mdl_seq[idx]  = seq;
        mdl_count     = idx + 1;
        return idx;
    endfunction

    // Computes the response to one request and updates the model table.
    function automatic t_rsp predict_route(t_req r);
        t_rsp             rsp;
        logic [COST_BITS:0] raw;
        logic [COST_BITS-1:0] sum;
        logic             is_self;
        logic             fresh;
        int               e;
        rsp.found       = 1'b0;
        rsp.next_hop    = '0;
        rsp.route_cost  = COST_INF;
        rsp.action      = ACT_NONE;
        rsp.broken_link = 1'b0;
        is_self = (r.dest_id == mdl_self_id);
        fresh   = 1'b0;
        e       = 0;
        if (r.func == FUNC_ADV) begin
            // The summed cost saturates to infinity.
            raw = {1'b0, r.adv_cost} + {1'b0, r.link_cost};
            sum = (r.adv_cost == COST_INF || raw >= {1'b0, COST_INF}) ?
                  COST_INF : raw[COST_BITS-1:0];
            if (!is_self) e = find_route(r.dest_id);
            rsp.found = is_self || (e != 0);
            if (r.first_row) begin
                mdl_nbr = r.dest_id;
                if (is_self) begin
                    mdl_newer = r.adv_seq > mdl_self_seq;
                end else if (e != 0) begin
                    mdl_newer = r.adv_seq > mdl_seq[e];
                end else begin
                    mdl_newer = 1'b1;
                    e = add_route(r.dest_id, r.dest_id, r.link_cost, r.adv_seq);
                    fresh = 1'b1;
                end
            end
            if (is_self) begin
                if (r.adv_seq[0]) begin
                    rsp.action      = ACT_OWN_ODD;
                    rsp.broken_link = 1'b1;
                end
            end else if (e != 0) begin
                if (mdl_next[e] == mdl_nbr && mdl_newer) begin
                    mdl_cost[e] = sum;
                    rsp.action  = fresh ? ACT_INSERT : ACT_REFRESH;
                end else if (r.adv_seq > mdl_seq[e]) begin
                    if ((mdl_cost[e] == COST_INF && r.adv_cost != COST_INF) ||
                        r.adv_cost == COST_INF) rsp.broken_link = 1'b1;
                    mdl_next[e] = mdl_nbr;
                    mdl_cost[e] = sum;
                    mdl_seq[e]  = r.adv_seq;
                    rsp.action  = fresh ? ACT_INSERT : ACT_REPLACE;
                end else if (r.adv_seq == mdl_seq[e] && mdl_cost[e] >= sum) begin
                    mdl_next[e] = mdl_nbr;
                    mdl_cost[e] = sum;
                    rsp.action  = fresh ? ACT_INSERT : ACT_REPLACE;
                end else if (fresh) begin
                    rsp.action = ACT_INSERT;
                end
            end else begin
                e = add_route(r.dest_id, mdl_nbr, sum, r.adv_seq);
                rsp.action = (e != 0) ? ACT_INSERT : ACT_FULL;
            end
        end else if (r.func == FUNC_BREAK) begin
            // Every learned route through the broken hop goes infinite.
            for (int i = 1; i < mdl_count; i++) begin
                if (mdl_next[i] == r.dest_id) begin
                    mdl_cost[i]     = COST_INF;
                    mdl_seq[i]      = mdl_seq[i] + SEQ_W'(1);
                    rsp.action      = ACT_BROKEN;
                    rsp.broken_link = 1'b1;
                end
            end
            if (!is_self) e = find_route(r.dest_id);
            rsp.found = is_self || (e != 0);
        end else if (r.func == FUNC_LOOK) begin
            if (!is_self) e = find_route(r.dest_id);
            rsp.found = is_self || (e != 0);
        end
        if (r.func != 2'd3) begin
            if (is_self) begin
                rsp.next_hop   = mdl_self_id;
                rsp.route_cost = '0;
            end else if (e != 0) begin
                rsp.next_hop   = mdl_next[e];
                rsp.route_cost = mdl_cost[e];
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string field, int unsigned exp_v, int unsigned got_v);
        $display("MISMATCH %s: expected %0h, got %0h", field, exp_v, got_v);
        error_count++;
    endtask

    // Sends one request, waits for acceptance and records its prediction.
    task automatic send_request(t_req r);
        if (!no_idle && $urandom_range(99) < 18) repeat ($urandom_range(1, 20)) @(posedge i_clk);
        @(posedge i_clk);
        start <= 1'b1;
        i_req <= r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        // Accepted at this edge.
        pending_rsp = {pending_rsp, predict_route(r)};
        idle_cycles = 0;
        start <= 1'b0;
    endtask

    function automatic t_req make_req(logic [1:0] func, logic [NODE_ID_BITS-1:0] dest,
                                      logic [COST_BITS-1:0] acost, logic [SEQ_W-1:0] aseq,
                                      logic [COST_BITS-1:0] link, logic first);
        t_req r;
        r.func      = func;
        r.dest_id   = dest;
        r.adv_cost  = acost;
        r.adv_seq   = aseq;
        r.link_cost = link;
        r.first_row = first;
        return r;
    endfunction

    // Register writes happen only once the table has gone quiet.
    task automatic write_register(logic idx, logic [CFG_W-1:0] data);
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SELF_ID) mdl_self_id = data[NODE_ID_BITS-1:0];
        else                    mdl_self_seq = data[SEQ_W-1:0];
        idle_cycles = 0;
    endtask

    // Checks every result strobe against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_valid) begin
            idle_cycles = 0;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_rsp.found !== exp_rsp.found)
                    report_mismatch("found", exp_rsp.found, o_rsp.found);
                if (o_rsp.next_hop !== exp_rsp.next_hop)
                    report_mismatch("next_hop", exp_rsp.next_hop, o_rsp.next_hop);
                if (o_rsp.route_cost !== exp_rsp.route_cost)
                    report_mismatch("route_cost", exp_rsp.route_cost, o_rsp.route_cost);
                if (o_rsp.action !== exp_rsp.action)
                    report_mismatch("action", exp_rsp.action, o_rsp.action);
                if (o_rsp.broken_link !== exp_rsp.broken_link)
                    report_mismatch("broken_link", exp_rsp.broken_link, o_rsp.broken_link);
            end
        end
    end

    // A run that stops making progress ends here.
    always @(posedge i_clk) begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Lookups and breaks on an empty table, plus the undefined function code.
    task automatic test_empty_table();
        send_request(make_req(FUNC_LOOK, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(FUNC_LOOK, 8'd200, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFE, 1'b1));
        send_request(make_req(FUNC_BREAK, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(FUNC_BREAK, 8'd77, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(2'd3, 8'd77, 16'h5555, 32'hAAAA_5555, 16'h2AAA, 1'b1));
    endtask

    // Insert, refresh, replace, keep and saturation, with advertisements from two neighbours.
    task automatic test_advertisements();
        send_request(make_req(FUNC_ADV, 8'd5, 16'd0, 32'd10, 16'd10, 1'b1));
        send_request(make_req(FUNC_ADV, 8'd9, 16'd3, 32'd10, 16'd10, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd12, 16'hFFFF, 32'd4, 16'd10, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd13, 16'd65000, 32'd4, 16'd600, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd6, 16'd0, 32'd2, 16'd1, 1'b1));
        send_request(make_req(FUNC_ADV, 8'd9, 16'd1, 32'd10, 16'd1, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd9, 16'd50, 32'd11, 16'd1, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd9, 16'd0, 32'd3, 16'd1, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd12, 16'd7, 32'd9, 16'd1, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd0, 16'd0, 32'd7, 16'd1, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd0, 16'd0, 32'd8, 16'd1, 1'b1));
    endtask

    // Breaking a next hop bumps the sequence of every route through it.
    task automatic test_link_breaks();
        send_request(make_req(FUNC_BREAK, 8'd5, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(FUNC_LOOK, 8'd13, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(FUNC_BREAK, 8'd6, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(FUNC_LOOK, 8'd9, 16'd0, 32'd0, 16'd0, 1'b0));
    endtask

    // Extreme register values, with the own entry advertised back.
    task automatic test_self_registers();
        write_register(CFG_SELF_ID, 32'd255);
        write_register(CFG_SELF_SEQ, 32'hFFFF_FFFF);
        send_request(make_req(FUNC_ADV, 8'd255, 16'd0, 32'hFFFF_FFFF, 16'd0, 1'b1));
        send_request(make_req(FUNC_LOOK, 8'd255, 16'd0, 32'd0, 16'd0, 1'b0));
        send_request(make_req(FUNC_ADV, 8'd9, 16'd0, 32'd20, 16'd2, 1'b0));
        write_register(CFG_SELF_ID, 32'd9);
        write_register(CFG_SELF_SEQ, 32'd0);
        send_request(make_req(FUNC_LOOK, 8'd9, 16'd0, 32'd0, 16'd0, 1'b0));
    endtask

    function automatic logic [SEQ_W-1:0] rand_seq();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 24);
        endcase
    endfunction

    function automatic logic [COST_BITS-1:0] rand_cost(bit is_link);
        case ($urandom_range(9))
            0:       return is_link ? 16'hFFFE : 16'hFFFF;
            1:       return COST_BITS'($urandom_range(0, is_link ? 65534 : 65535));
            2:       return COST_BITS'(16'hFF00 + $urandom_range(0, 254));
            default: return COST_BITS'($urandom_range(0, 40));
        endcase
    endfunction

    // Ids come mostly from a small pool so that routes are hit again.
    function automatic logic [NODE_ID_BITS-1:0] rand_id();
        logic [NODE_ID_BITS-1:0] base;
        if ($urandom_range(9) == 0) return NODE_ID_BITS'($urandom_range(0, 255));
        if ($urandom_range(19) == 0) return mdl_self_id;
        base = NODE_ID_BITS'(240 + $urandom_range(0, 15));
        return base ^ NODE_ID_BITS'($urandom_range(0, 3) << 4);
    endfunction

    // Advertisement bursts, breaks, lookups and noise, across several settings.
    task automatic test_random_traffic(int n_items);
        t_req r;
        int   sent;
        int   burst;
        logic [COST_BITS-1:0] link;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 450 == 0 && sent != 0) begin
                write_register(CFG_SELF_ID, $urandom_range(0, 255));
                write_register(CFG_SELF_SEQ, rand_seq());
            end
            no_idle = (sent >= 600 && sent < 800);
            case ($urandom_range(19))
                0, 1, 2: begin
                    send_request(make_req(FUNC_BREAK, rand_id(), COST_BITS'($urandom()),
                                          $urandom(), COST_BITS'($urandom()),
                                          1'($urandom_range(1))));
                    sent++;
                end
                3, 4, 5: begin
                    send_request(make_req(FUNC_LOOK, rand_id(), COST_BITS'($urandom()),
                                          $urandom(), COST_BITS'($urandom()),
                                          1'($urandom_range(1))));
                    sent++;
                end
                6: begin
                    r = make_req(FUNC_ADV, rand_id(), rand_cost(0), rand_seq(),
                                 rand_cost(1), 1'($urandom_range(1)));
                    if ($urandom_range(3) == 0) r.func = 2'd3;
                    send_request(r);
                    sent++;
                end
                default: begin
                    // A well-formed advertisement: the neighbour's own row first.
                    link  = rand_cost(1);
                    burst = $urandom_range(1, 6);
                    send_request(make_req(FUNC_ADV, rand_id(), 16'd0, rand_seq(), link, 1'b1));
                    sent++;
                    repeat (burst) begin
                        send_request(make_req(FUNC_ADV, rand_id(), rand_cost(0), rand_seq(),
                                              link, 1'b0));
                        sent++;
                    end
                end
            endcase
        end
        no_idle = 1'b0;
    endtask

    initial begin
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_SELF_ID;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        mdl_count   = 1;
        mdl_nbr     = '0;
        mdl_newer   = 1'b0;
        mdl_self_id = '0;
        mdl_self_seq = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_advertisements();
        test_link_breaks();
        test_self_registers();
        test_random_traffic(1800);

        wait (pending_rsp.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_rsp.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
